// File: hdl/cmg_pkg.sv
// shared types and constants for the colorize max3x3 gain block
package cmg_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int WIDTH_MIN      = 3;
	localparam int HEIGHT_MIN     = 3;
	localparam int HEIGHT_MAX     = 4096;

	localparam int CH_W           = 8;
	localparam int WIDTH_W        = 12;
	localparam int HEIGHT_W       = 13;
	localparam int ROW_W          = 12;
	localparam int GAIN_W         = 9;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int GAIN_ONE       = 1 << GAIN_FRAC_BITS;
	localparam int FAC_W          = GAIN_FRAC_BITS + 2;

	localparam int QDEPTH         = 4;
	localparam int QCNT_W         = $clog2(QDEPTH + 1);

	localparam int ADDR_W         = 4;
	localparam int DATA_W         = 32;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GAIN   = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} cmg_pix_t;

	typedef struct packed {
		cmg_pix_t upper;
		cmg_pix_t middle;
	} cmg_line_t;

	// dominance flags per channel
	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} cmg_dom_t;

	// classified word handed from front to back, column travels beside it
	typedef struct packed {
		cmg_pix_t         pix;
		cmg_dom_t         dom;
		logic             last;
		logic [ROW_W-1:0] row;
	} cmg_cls_t;

endpackage

// File: hdl/colorize_max3x3_gain.sv
// top level: register port, front end, word queue and back end
// Streaming 3x3 max-dominance colorizer for BGR pixels in raster order. One pixel is taken per
// clock while the word queue has credit; the rate is set by the single line memory (one read and
// one write per pixel, at different columns) and the per-channel multiplier of the back end. Only
// interior pixels give a word; it passes the s1 and s2 registers, a four-word queue that keeps
// input flowing while the output is stalled, and the output register. Geometry and gain must be
// programmed via the register port while the stream is idle; the block does not enforce this.
module colorize_max3x3_gain #(
	parameter int MAX_WIDTH = cmg_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cmg_pkg::ADDR_W-1:0]          paddr,
	input  logic [cmg_pkg::DATA_W-1:0]          pwdata,
	output logic [cmg_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cmg_pkg::CH_W-1:0]            in_blue,
	input  logic [cmg_pkg::CH_W-1:0]            in_green,
	input  logic [cmg_pkg::CH_W-1:0]            in_red,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cmg_pkg::CH_W-1:0]            out_blue,
	output logic [cmg_pkg::CH_W-1:0]            out_green,
	output logic [cmg_pkg::CH_W-1:0]            out_red,
	output logic [cmg_pkg::ROW_W-1:0]           out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
	output logic                                frame_done
);
	import cmg_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WORD_W = $bits(cmg_cls_t) + COL_W;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [GAIN_W-1:0]   gain_q;
	logic                cfg_wr;

	cmg_pix_t            in_pix;
	logic                push;
	cmg_cls_t            push_cls;
	logic [COL_W-1:0]    push_col;
	logic                pop;
	logic                q_valid;
	logic [WORD_W-1:0]   q_head;
	logic [QCNT_W-1:0]   q_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
			gain_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_GAIN:   prdata = DATA_W'(gain_q);
			default:    prdata = '0;
		endcase
	end

	assign in_pix = '{red: in_red, green: in_green, blue: in_blue};

	cmg_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.width    (width_q),
		.height   (height_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_pix   (in_pix),
		.q_count  (q_count),
		.push     (push),
		.push_cls (push_cls),
		.push_col (push_col)
	);

	cmg_fifo #(
		.DEPTH  (QDEPTH),
		.DATA_W (WORD_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cls, push_col}),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head),
		.count     (q_count)
	);

	cmg_back #(
		.COL_W (COL_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain       (gain_q),
		.q_valid    (q_valid),
		.q_cls      (cmg_cls_t'(q_head[WORD_W-1:COL_W])),
		.q_col      (q_head[COL_W-1:0]),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_done (frame_done)
	);

endmodule

// File: hdl/cmg_front.sv
// front end: position tracking, line memory, 3x3 window maxima and dominance
module cmg_front #(
	parameter int MAX_WIDTH = cmg_pkg::MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cmg_pkg::WIDTH_W-1:0]   width,
	input  logic [cmg_pkg::HEIGHT_W-1:0]  height,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cmg_pkg::cmg_pix_t             in_pix,
	input  logic [cmg_pkg::QCNT_W-1:0]    q_count,
	output logic                          push,
	output cmg_pkg::cmg_cls_t             push_cls,
	output logic [COL_W-1:0]              push_col
);
	import cmg_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic             accept;
	logic             emit;
	logic             last;

	logic             valid_s1;
	logic             emit_s1;
	logic             last_s1;
	cmg_pix_t         px_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;

	logic             valid_s2;
	logic             emit_s2;
	logic             last_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;

	cmg_line_t        line_mem [MAX_WIDTH];
	cmg_line_t        line_rd_q;
	cmg_pix_t         win_max_q [3];
	cmg_pix_t         mid_q [2];
	cmg_pix_t         col_max;
	cmg_pix_t         mx;
	cmg_dom_t         dom;
	logic [QCNT_W:0]  used;

	function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// effective geometry
	always_comb begin
		if (32'(width) > MAX_WIDTH) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else if (width < WIDTH_W'(WIDTH_MIN)) begin
			last_col = COL_W'(WIDTH_MIN - 1);
		end else begin
			last_col = COL_W'(width - WIDTH_W'(1));
		end
		if (height > HEIGHT_W'(HEIGHT_MAX)) begin
			last_row = ROW_W'(HEIGHT_MAX - 1);
		end else if (height < HEIGHT_W'(HEIGHT_MIN)) begin
			last_row = ROW_W'(HEIGHT_MIN - 1);
		end else begin
			last_row = ROW_W'(height - HEIGHT_W'(1));
		end
	end

	always_comb begin
		col  = (col_q > last_col) ? last_col : col_q;
		row  = (row_q > last_row) ? last_row : row_q;
		emit = (row >= ROW_W'(2)) && (col >= COL_W'(2));
		last = (row == last_row) && (col == last_col);
	end

	// credit for queue slots, counting words still in flight
	always_comb begin
		used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1 && emit_s1)
			+ (QCNT_W+1)'(valid_s2 && emit_s2);
		in_ready = used < (QCNT_W+1)'(QDEPTH);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				if (col >= last_col) begin
					col_q <= '0;
					row_q <= (row >= last_row) ? '0 : row + ROW_W'(1);
				end else begin
					col_q <= col + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1   <= emit;
			last_s1   <= last;
			px_s1     <= in_pix;
			col_s1    <= col;
			row_s1    <= row;
			line_rd_q <= line_mem[col];
		end
		if (valid_s1) begin
			line_mem[col_s1] <= '{upper: line_rd_q.middle, middle: px_s1};
			emit_s2      <= emit_s1;
			last_s2      <= last_s1;
			col_s2       <= col_s1;
			row_s2       <= row_s1;
			win_max_q[0] <= win_max_q[1];
			win_max_q[1] <= win_max_q[2];
			win_max_q[2] <= col_max;
			mid_q[0]     <= mid_q[1];
			mid_q[1]     <= line_rd_q.middle;
		end
	end

	// max of the incoming column
	always_comb begin
		col_max.blue  = max2(max2(line_rd_q.upper.blue, line_rd_q.middle.blue), px_s1.blue);
		col_max.green = max2(max2(line_rd_q.upper.green, line_rd_q.middle.green), px_s1.green);
		col_max.red   = max2(max2(line_rd_q.upper.red, line_rd_q.middle.red), px_s1.red);
	end

	// window max and dominance
	always_comb begin
		mx.blue   = max2(max2(win_max_q[0].blue, win_max_q[1].blue), win_max_q[2].blue);
		mx.green  = max2(max2(win_max_q[0].green, win_max_q[1].green), win_max_q[2].green);
		mx.red    = max2(max2(win_max_q[0].red, win_max_q[1].red), win_max_q[2].red);
		dom.blue  = (mx.blue > mx.red) && (mx.blue > mx.green);
		dom.green = (mx.green > mx.red) && (mx.green >= mx.blue);
		dom.red   = (mx.red >= mx.green) && (mx.red >= mx.blue);
	end

	assign push          = valid_s2 && emit_s2;
	assign push_cls.pix  = mid_q[0];
	assign push_cls.dom  = dom;
	assign push_cls.last = last_s2;
	assign push_cls.row  = row_s2 - ROW_W'(1);
	assign push_col      = col_s2 - COL_W'(1);

	// back to back pixels never touch the same line memory column
	a_col_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 |-> col_s1 != col_s2)
		else $error("line memory column hazard");

endmodule

// File: hdl/cmg_fifo.sv
// small register queue between front and back
module cmg_fifo #(
	parameter int DEPTH  = cmg_pkg::QDEPTH,
	parameter int DATA_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [DATA_W-1:0]           push_data,
	input  logic                        pop,
	output logic                        not_empty,
	output logic [DATA_W-1:0]           head,
	output logic [$clog2(DEPTH+1)-1:0]  count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q < CNT_W'(DEPTH))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue underflow");

endmodule

// File: hdl/cmg_back.sv
// back end: gain scaling, saturation and output register
module cmg_back #(
	parameter int COL_W = $clog2(cmg_pkg::MAX_WIDTH_DEF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cmg_pkg::GAIN_W-1:0]    gain,
	input  logic                          q_valid,
	input  cmg_pkg::cmg_cls_t             q_cls,
	input  logic [COL_W-1:0]              q_col,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cmg_pkg::CH_W-1:0]      out_blue,
	output logic [cmg_pkg::CH_W-1:0]      out_green,
	output logic [cmg_pkg::CH_W-1:0]      out_red,
	output logic [cmg_pkg::ROW_W-1:0]     out_row,
	output logic [COL_W-1:0]              out_col,
	output logic                          frame_done
);
	import cmg_pkg::*;

	localparam int PROD_W = CH_W + FAC_W;
	localparam int SHR_W  = PROD_W - GAIN_FRAC_BITS;

	logic              out_valid_q;
	logic [GAIN_W-1:0] gain_sat;
	logic [FAC_W-1:0]  fac_up;
	logic [FAC_W-1:0]  fac_dn;

	function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] v,
		input logic [FAC_W-1:0] fac);
		logic [PROD_W-1:0] prod;
		logic [SHR_W-1:0]  shr;
		prod = PROD_W'(v) * PROD_W'(fac);
		shr  = prod[PROD_W-1:GAIN_FRAC_BITS];
		return (shr > SHR_W'(255)) ? {CH_W{1'b1}} : shr[CH_W-1:0];
	endfunction

	always_comb begin
		gain_sat = (gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain;
		fac_up   = FAC_W'(GAIN_ONE) + FAC_W'(gain_sat);
		fac_dn   = FAC_W'(GAIN_ONE) - FAC_W'(gain_sat);
	end

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_blue   <= scale_ch(q_cls.pix.blue, q_cls.dom.blue ? fac_up : fac_dn);
			out_green  <= scale_ch(q_cls.pix.green, q_cls.dom.green ? fac_up : fac_dn);
			out_red    <= scale_ch(q_cls.pix.red, q_cls.dom.red ? fac_up : fac_dn);
			out_row    <= q_cls.row;
			out_col    <= q_col;
			frame_done <= q_cls.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule
